// File: rtl/ddo_pkg.sv
// package for the differential drive odometry unit
// widths, fixed-point constants, command/status types and the cordic atan table
// no dependencies
package ddo_pkg;

    localparam int ANG_W            = 16;
    localparam int RAD_W            = 16;
    localparam int TRK_W            = 20;
    localparam int POS_W            = 32;
    localparam int IDX_W            = 2;
    localparam int CFG_W            = 20;
    localparam int MUL_W            = 32;
    localparam int PROD_W           = 64;
    localparam int TRV_W            = 28;
    localparam int SUM_W            = 29;
    localparam int DIV_BITS         = 51;
    localparam int CNT_W            = 6;
    localparam int STEP_W           = 5;
    localparam int CRD_W            = 34;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [IDX_W-1:0] REG_RIGHT_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_RADIUS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_AXLE_TRACK   = 2'd2;

    localparam logic [TRK_W-1:0] TRACK_RESET    = 20'd65536;
    localparam logic [MUL_W-1:0] TWO_PI_Q28     = 32'd1686629713;
    localparam logic [MUL_W-1:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [CRD_W-1:0] CORDIC_GAIN    = 34'd652032875;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MR1,
        OP_MR2,
        OP_ML1,
        OP_ML2,
        OP_TL,
        OP_DIVSET,
        OP_DIV,
        OP_HLO,
        OP_HHI,
        OP_HCAP,
        OP_FOLD,
        OP_MZ,
        OP_CINIT,
        OP_CORD,
        OP_MX,
        OP_MY,
        OP_FIN,
        OP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STEP_W-1:0]   step;
    } dp_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic out_busy;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MR1,
        ST_MR2,
        ST_ML1,
        ST_ML2,
        ST_TL,
        ST_DIVSET,
        ST_DIV,
        ST_HLO,
        ST_HHI,
        ST_HCAP,
        ST_FOLD,
        ST_MZ,
        ST_CINIT,
        ST_CORD,
        ST_MX,
        ST_MY,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd843314857;
            5'd1:    r = 32'd497837829;
            5'd2:    r = 32'd263043837;
            5'd3:    r = 32'd133525159;
            5'd4:    r = 32'd67021687;
            5'd5:    r = 32'd33543516;
            5'd6:    r = 32'd16775851;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194283;
            5'd9:    r = 32'd2097149;
            5'd10:   r = 32'd1048576;
            5'd11:   r = 32'd524288;
            5'd12:   r = 32'd262144;
            5'd13:   r = 32'd131072;
            5'd14:   r = 32'd65536;
            5'd15:   r = 32'd32768;
            5'd16:   r = 32'd16384;
            5'd17:   r = 32'd8192;
            5'd18:   r = 32'd4096;
            5'd19:   r = 32'd2048;
            5'd20:   r = 32'd1024;
            5'd21:   r = 32'd512;
            5'd22:   r = 32'd256;
            5'd23:   r = 32'd128;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ddo_ctrl.sv
// sequencing state machine of the odometry unit
// issues one datapath command per cycle, counts divider and cordic steps; uses ddo_pkg
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ddo_pkg::dp_stat_t stat,
    output ddo_pkg::dp_cmd_t  cmd
);
    import ddo_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.have_prev ? ST_MR1 : ST_DONE;
                end
            end
            ST_MR1:    state_next = ST_MR2;
            ST_MR2:    state_next = ST_ML1;
            ST_ML1:    state_next = ST_ML2;
            ST_ML2:    state_next = ST_TL;
            ST_TL:     state_next = ST_DIVSET;
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    state_next = ST_HLO;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HLO:    state_next = ST_HHI;
            ST_HHI:    state_next = ST_HCAP;
            ST_HCAP:   state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_MZ;
            ST_MZ:     state_next = ST_CINIT;
            ST_CINIT:  state_next = ST_CORD;
            ST_CORD:
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_MX;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MX:     state_next = ST_MY;
            ST_MY:     state_next = ST_FIN;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.step = cnt_reg[STEP_W-1:0];
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.op   = in_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_MR1:    cmd.op = OP_MR1;
            ST_MR2:    cmd.op = OP_MR2;
            ST_ML1:    cmd.op = OP_ML1;
            ST_ML2:    cmd.op = OP_ML2;
            ST_TL:     cmd.op = OP_TL;
            ST_DIVSET: cmd.op = OP_DIVSET;
            ST_DIV:    cmd.op = OP_DIV;
            ST_HLO:    cmd.op = OP_HLO;
            ST_HHI:    cmd.op = OP_HHI;
            ST_HCAP:   cmd.op = OP_HCAP;
            ST_FOLD:   cmd.op = OP_FOLD;
            ST_MZ:     cmd.op = OP_MZ;
            ST_CINIT:  cmd.op = OP_CINIT;
            ST_CORD:   cmd.op = OP_CORD;
            ST_MX:     cmd.op = OP_MX;
            ST_MY:     cmd.op = OP_MY;
            ST_FIN:    cmd.op = OP_FIN;
            ST_DONE:   cmd.op = stat.out_busy ? OP_NONE : OP_LOAD;
            default:   cmd.op = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !stat.have_prev) |=> state_reg == ST_DONE)
        else $error("first sample did not go straight to result");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV && state_reg != ST_CORD) |-> cnt_reg == '0)
        else $error("step counter not cleared outside iteration");
    a_cord_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CORD |-> cnt_reg < CNT_W'(CORDIC_STEPS))
        else $error("cordic step count overrun");
`endif

endmodule

// File: rtl/ddo_dp.sv
// datapath of the odometry unit: config registers, pose, shared multiplier,
// radix-2 divider, iterative cordic and output register; uses ddo_pkg
module ddo_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [ddo_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]      cfg_data,
    input  logic [ddo_pkg::ANG_W-1:0]      right_angle,
    input  logic [ddo_pkg::ANG_W-1:0]      left_angle,
    input  ddo_pkg::dp_cmd_t               cmd,
    output ddo_pkg::dp_stat_t              stat,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic signed [ddo_pkg::POS_W-1:0] pos_x,
    output logic signed [ddo_pkg::POS_W-1:0] pos_y,
    output logic [ddo_pkg::ANG_W-1:0]      heading
);
    import ddo_pkg::*;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] p,
                                                 input logic [25:0] d);
        logic [POS_W+1:0] s;
        logic [POS_W-1:0] r;
        s = {{2{p[POS_W-1]}}, p} + {{8{d[25]}}, d};
        if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111)
        begin
            r = s[POS_W-1:0];
        end
        else
        begin
            r = s[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic [RAD_W-1:0]  rad_r_reg, rad_l_reg;
    logic [TRK_W-1:0]  track_reg;
    logic [ANG_W-1:0]  last_r_reg, last_l_reg;
    logic              have_prev_reg;
    logic [POS_W-1:0]  pose_x_reg, pose_x_next;
    logic [POS_W-1:0]  pose_y_reg, pose_y_next;
    logic [ANG_W-1:0]  head_reg, head_next;
    logic              out_valid_reg, out_valid_next;

    logic [ANG_W-1:0]  dr_mag_reg, dl_mag_reg;
    logic              dr_neg_reg, dl_neg_reg;
    logic [PROD_W-1:0] mul_reg;
    logic [TRV_W-1:0]  tr_reg, tl_reg;
    logic [SUM_W-1:0]  sum_mag_reg;
    logic              sum_neg_reg, dneg_reg, zq_reg;
    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [TRK_W-1:0]  rem_reg, rem_next;
    logic [31:0]       lohi_reg, hfull_reg, hhalf_reg;
    logic [30:0]       amag_reg;
    logic              aneg_reg, flip_reg, sgn_reg;
    logic signed [CRD_W-1:0] x_reg, y_reg, z_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg;
    logic [ANG_W-1:0]  out_h_reg;

    logic [ANG_W-1:0]  dr16, dl16;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] t_rnd;
    logic [TRV_W-1:0]  t_mag, t_cur;
    logic [SUM_W-1:0]  diff, sum, dmag, smag;
    logic [TRK_W:0]    trial;
    logic              ge;
    logic [DIV_BITS-1:0] q_eff;
    logic [32:0]       prod33;
    logic [31:0]       hf, hh, mid, ang, amag32;
    logic              flip;
    logic [PROD_W-1:0] z_rnd, p_rnd;
    logic [31:0]       zmag;
    logic [CRD_W-1:0]  z_init;
    logic signed [CRD_W-1:0] xs, ys, atz;
    logic [CRD_W-1:0]  cv, cmag;
    logic [24:0]       dmv;
    logic [25:0]       delta;
    logic [31:0]       hsum;

    always_comb
    begin
        dr16   = right_angle - last_r_reg;
        dl16   = left_angle - last_l_reg;

        t_rnd  = mul_reg + (64'd1 << 35);
        t_mag  = t_rnd[63:36];
        if (cmd.op == OP_TL)
        begin
            t_cur = dl_neg_reg ? (TRV_W'(0) - t_mag) : t_mag;
        end
        else
        begin
            t_cur = dr_neg_reg ? (TRV_W'(0) - t_mag) : t_mag;
        end

        diff   = {tr_reg[TRV_W-1], tr_reg} - {tl_reg[TRV_W-1], tl_reg};
        sum    = {tr_reg[TRV_W-1], tr_reg} + {tl_reg[TRV_W-1], tl_reg};
        dmag   = diff[SUM_W-1] ? (SUM_W'(0) - diff) : diff;
        smag   = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;

        trial  = {rem_reg, num_reg[DIV_BITS-1]};
        ge     = trial >= {1'b0, track_reg};
        q_eff  = zq_reg ? '0 : num_reg;

        prod33 = mul_reg[32:0] + {1'b0, lohi_reg};
        hf     = dneg_reg ? (32'd0 - prod33[31:0]) : prod33[31:0];
        hh     = dneg_reg ? (32'd0 - prod33[32:1]) : prod33[32:1];

        mid    = {head_reg, 16'h0000} + hhalf_reg;
        flip   = mid[31] ^ mid[30];
        ang    = {mid[31] ^ flip, mid[30:0]};
        amag32 = ang[31] ? (32'd0 - ang) : ang;

        z_rnd  = mul_reg + (64'd1 << 29);
        zmag   = z_rnd[61:30];
        z_init = aneg_reg ? (CRD_W'(0) - {2'b00, zmag}) : {2'b00, zmag};

        xs     = x_reg >>> cmd.step;
        ys     = y_reg >>> cmd.step;
        atz    = $signed({2'b00, atan_q30(cmd.step)});

        if (cmd.op == OP_MX)
        begin
            cv = flip_reg ? (CRD_W'(0) - x_reg) : x_reg;
        end
        else
        begin
            cv = flip_reg ? (CRD_W'(0) - y_reg) : y_reg;
        end
        cmag   = cv[CRD_W-1] ? (CRD_W'(0) - cv) : cv;

        p_rnd  = mul_reg + (64'd1 << 38);
        dmv    = p_rnd[63:39];
        delta  = sgn_reg ? (26'd0 - {1'b0, dmv}) : {1'b0, dmv};

        hsum   = {head_reg, 16'h0000} + hfull_reg + 32'h0000_8000;

        rem_next = ge ? TRK_W'(trial - {1'b0, track_reg}) : trial[TRK_W-1:0];
        num_next = {num_reg[DIV_BITS-2:0], ge};

        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MR1:
            begin
                mul_a = {16'h0000, dr_mag_reg};
                mul_b = {16'h0000, rad_r_reg};
            end
            OP_MR2, OP_ML2:
            begin
                mul_a = mul_reg[31:0];
                mul_b = TWO_PI_Q28;
            end
            OP_ML1:
            begin
                mul_a = {16'h0000, dl_mag_reg};
                mul_b = {16'h0000, rad_l_reg};
            end
            OP_HLO:
            begin
                mul_a = q_eff[31:0];
                mul_b = INV_TWO_PI_Q32;
            end
            OP_HHI:
            begin
                mul_a = {13'd0, q_eff[DIV_BITS-1:32]};
                mul_b = INV_TWO_PI_Q32;
            end
            OP_MZ:
            begin
                mul_a = {1'b0, amag_reg};
                mul_b = TWO_PI_Q28;
            end
            OP_MX, OP_MY:
            begin
                mul_a = {3'd0, sum_mag_reg};
                mul_b = cmag[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        pose_x_next    = (cmd.op == OP_MY) ? sat_add(pose_x_reg, delta) : pose_x_reg;
        pose_y_next    = (cmd.op == OP_FIN) ? sat_add(pose_y_reg, delta) : pose_y_reg;
        head_next      = (cmd.op == OP_FIN) ? hsum[31:16] : head_reg;
        out_valid_next = (cmd.op == OP_LOAD) ? 1'b1 : (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_r_reg     <= '0;
            rad_l_reg     <= '0;
            track_reg     <= TRACK_RESET;
            last_r_reg    <= '0;
            last_l_reg    <= '0;
            have_prev_reg <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RIGHT_RADIUS: rad_r_reg <= cfg_data[RAD_W-1:0];
                    REG_LEFT_RADIUS:  rad_l_reg <= cfg_data[RAD_W-1:0];
                    REG_AXLE_TRACK:   track_reg <= cfg_data[TRK_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.op == OP_ACCEPT)
            begin
                last_r_reg    <= right_angle;
                last_l_reg    <= left_angle;
                have_prev_reg <= 1'b1;
            end
            pose_x_reg    <= pose_x_next;
            pose_y_reg    <= pose_y_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_ACCEPT:
            begin
                dr_neg_reg <= dr16[ANG_W-1];
                dr_mag_reg <= dr16[ANG_W-1] ? (ANG_W'(0) - dr16) : dr16;
                dl_neg_reg <= dl16[ANG_W-1];
                dl_mag_reg <= dl16[ANG_W-1] ? (ANG_W'(0) - dl16) : dl16;
            end
            OP_ML1: tr_reg <= t_cur;
            OP_TL:  tl_reg <= t_cur;
            OP_DIVSET:
            begin
                dneg_reg    <= diff[SUM_W-1];
                sum_neg_reg <= sum[SUM_W-1];
                sum_mag_reg <= smag;
                num_reg     <= {dmag[26:0], 24'd0};
                rem_reg     <= '0;
                zq_reg      <= (track_reg == '0);
            end
            OP_DIV:
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
            OP_HHI: lohi_reg <= mul_reg[63:32];
            OP_HCAP:
            begin
                hfull_reg <= hf;
                hhalf_reg <= hh;
            end
            OP_FOLD:
            begin
                flip_reg <= flip;
                aneg_reg <= ang[31];
                amag_reg <= amag32[30:0];
            end
            OP_CINIT:
            begin
                z_reg <= z_init;
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
            end
            OP_CORD:
            begin
                if (!z_reg[CRD_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atz;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atz;
                end
            end
            OP_MX, OP_MY: sgn_reg <= sum_neg_reg ^ cv[CRD_W-1];
            OP_LOAD:
            begin
                out_x_reg <= pose_x_reg;
                out_y_reg <= pose_y_reg;
                out_h_reg <= head_reg;
            end
            default: ;
        endcase
    end

    assign stat.have_prev = have_prev_reg;
    assign stat.out_busy  = out_valid_reg & out_stall;
    assign out_valid      = out_valid_reg;
    assign pos_x          = out_x_reg;
    assign pos_y          = out_y_reg;
    assign heading        = out_h_reg;

`ifndef SYNTHESIS
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_LOAD))
        else $error("result valid without load");
    a_prev_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |=> have_prev_reg)
        else $error("previous sample flag dropped");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV && track_reg != '0) |=> rem_reg < track_reg)
        else $error("divider remainder out of range");
`endif

endmodule

// File: rtl/differential_drive_odometry_unit.sv
// top level of the differential drive wheel odometry unit
// joins the sequencer ddo_ctrl and the datapath ddo_dp; uses ddo_pkg
//
//   channel   signals                                        flow
//   in        in_valid, in_stall, right_angle, left_angle    stall from block
//   out       out_valid, out_stall, pos_x, pos_y, heading    stall from sink
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data      ready always high
//
// a result is computed by the 51-step radix-2 divider and the cordic iterations
// on one shared multiplier; the first sample after reset goes straight to the
// result without computing travel, and the next beat is taken only once the
// result is in the output register. reset clears pose, previous angles and radii
// and sets the axle track to 65536; a result waits in the output register while
// stalled, and the block holds input stall until it is free
module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ddo_pkg::ANG_W-1:0]        right_angle,
    input  logic [ddo_pkg::ANG_W-1:0]        left_angle,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [ddo_pkg::POS_W-1:0] pos_x,
    output logic signed [ddo_pkg::POS_W-1:0] pos_y,
    output logic [ddo_pkg::ANG_W-1:0]        heading,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddo_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]        cfg_data
);
    import ddo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ddo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .right_angle (right_angle),
        .left_angle  (left_angle),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading)
    );

endmodule

// File: tb/testbench.sv
// self-checking testbench for differential_drive_odometry_unit
// drives wheel angle beats and register writes, predicts each pose in a local class
// depends on ddo_pkg and the rtl of the odometry unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ddo_pkg::*;

    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANG_W-1:0]        hdg;
    } pose_t;

    class pose_predictor;
        pose_t          expected_poses[$];
        int             errors;
        bit [RAD_W-1:0] r_radius, l_radius;
        bit [TRK_W-1:0] track;
        int             px, py;
        bit [15:0]      hdg, last_r, last_l;
        bit             primed;
        longint         atan_tab[24];

        function new();
            atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                         16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                         262144, 131072, 65536, 32768, 16384, 8192,
                         4096, 2048, 1024, 512, 256, 128};
            track = TRACK_RESET;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RIGHT_RADIUS: r_radius = data[RAD_W-1:0];
                REG_LEFT_RADIUS:  l_radius = data[RAD_W-1:0];
                REG_AXLE_TRACK:   track = data;
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int s);
            longint half;
            half = longint'(1) << (s - 1);
            if (v >= 0)
                return (v + half) >>> s;
            return -((-v + half) >>> s);
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fffffff;
            if (v < -64'sd2147483648)
                return 32'h80000000;
            return int'(v);
        endfunction

        function void sin_cos(bit [31:0] ang, output longint c, output longint s);
            bit     flip;
            longint a, z, x, y, xs, ys;
            flip = 0;
            x = 652032875;
            y = 0;
            if (ang >= 32'h40000000 && ang < 32'hc0000000)
            begin
                ang = ang + 32'h80000000;
                flip = 1;
            end
            a = longint'(int'(ang));
            z = round_shift(a * 64'sd1686629713, 30);
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
                else
                begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_angles(bit [15:0] ra, bit [15:0] la);
            longint    dr, dl, tr, tl, diff, c, s;
            bit [63:0] mag, q, prod;
            bit [31:0] hfull, hhalf, base, mid;
            pose_t     p;
            if (primed)
            begin
                dr = longint'(shortint'(ra - last_r));
                dl = longint'(shortint'(la - last_l));
                tr = round_shift(dr * longint'(r_radius) * 64'sd1686629713, 36);
                tl = round_shift(dl * longint'(l_radius) * 64'sd1686629713, 36);
                diff = tr - tl;
                prod = 0;
                if (track != 0)
                begin
                    mag = 64'(diff < 0 ? -diff : diff) << 24;
                    q = mag / 64'(track);
                    prod = (q >> 32) * 64'd683565276
                           + (((q & 64'hffffffff) * 64'd683565276) >> 32);
                end
                hfull = prod[31:0];
                hhalf = prod[32:1];
                if (diff < 0)
                begin
                    hfull = -hfull;
                    hhalf = -hhalf;
                end
                base = {hdg, 16'h0};
                mid = base + hhalf;
                sin_cos(mid, c, s);
                px = clamp32(longint'(px) + round_shift((tr + tl) * c, 39));
                py = clamp32(longint'(py) + round_shift((tr + tl) * s, 39));
                hfull = base + hfull + 32'h8000;
                hdg = hfull[31:16];
            end
            last_r = ra;
            last_l = la;
            primed = 1;
            p.x = px;
            p.y = py;
            p.hdg = hdg;
            expected_poses.push_back(p);
        endfunction

        function void check_pose(logic signed [31:0] x, logic signed [31:0] y, logic [15:0] h);
            pose_t p;
            if (expected_poses.size() == 0)
            begin
                $error("pose beat with nothing expected");
                errors++;
                return;
            end
            p = expected_poses.pop_front();
            if (x !== p.x)
            begin
                $error("pos_x expected %0d got %0d", p.x, x);
                errors++;
            end
            if (y !== p.y)
            begin
                $error("pos_y expected %0d got %0d", p.y, y);
                errors++;
            end
            if (h !== p.hdg)
            begin
                $error("heading expected %0d got %0d", p.hdg, h);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid, in_stall;
    logic [ANG_W-1:0]        right_angle, left_angle;
    logic                    out_valid, out_stall;
    logic signed [POS_W-1:0] pos_x, pos_y;
    logic [ANG_W-1:0]        heading;
    logic                    cfg_valid, cfg_ready;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    pose_predictor odo = new();
    bit            hold_req, hold_done;
    int            hold_left, stall_mode, stall_win, idle_cycles;
    int            burst_left;
    bit [15:0]     cur_r, cur_l;

    differential_drive_odometry_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // sink stall patterns plus one long hold-off
    always @(posedge clk)
    begin
        if (stall_win == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_win <= $urandom_range(50, 300);
        end
        else
            stall_win <= stall_win - 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 600;
            out_stall <= 1'b1;
        end
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ~out_stall;
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            odo.check_pose(pos_x, pos_y, heading);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        while (odo.expected_poses.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_regs(int rr, int lr, int trk, bit junk);
        logic [IDX_W-1:0] idx[4];
        logic [CFG_W-1:0] val[4];
        int               n;
        idx = '{REG_RIGHT_RADIUS, REG_LEFT_RADIUS, REG_AXLE_TRACK, REG_NONE};
        val[0] = {4'($urandom), 16'(rr)};
        val[1] = {4'($urandom), 16'(lr)};
        val[2] = 20'(trk);
        val[3] = 20'($urandom);
        n = junk ? 4 : 3;
        in_valid <= 1'b0;
        wait_idle();
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            odo.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_angles(bit [15:0] ra, bit [15:0] la);
        int gap;
        in_valid <= 1'b1;
        right_angle <= ra;
        left_angle <= la;
        do
            @(posedge clk);
        while (in_stall);
        odo.note_angles(ra, la);
        cur_r = ra;
        cur_l = la;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic bit [15:0] next_angle(bit [15:0] a, int span);
        case ($urandom_range(0, 9))
            7: return 16'($urandom);
            8: return a + ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
            9: return a;
            default: return a + 16'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    task automatic random_run(int n);
        int span;
        span = $urandom_range(0, 3) == 0 ? 30000 : $urandom_range(1, 3000);
        for (int i = 0; i < n; i++)
            send_angles(next_angle(cur_r, span), next_angle(cur_l, span));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        right_angle <= '0;
        left_angle <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample, then reset registers give no travel
        send_angles(16'hffff, 16'h0000);
        send_angles(16'h1234, 16'h8000);
        send_angles(16'h0000, 16'hffff);
        write_regs(30000, 30000, 65536, 1'b0);
        send_angles(16'h7fff, 16'hffff);
        send_angles(16'hffff, 16'h7fff);
        send_angles(16'h7fff, 16'h7fff);
        send_angles(16'h8000, 16'h8000);
        send_angles(16'h0000, 16'h0000);
        send_angles(16'h0001, 16'hffff);
        send_angles(16'h8001, 16'h7fff);
        send_angles(16'h8001, 16'h7fff);
        for (int i = 0; i < 6; i++)
            send_angles(cur_r + 16'd3000, cur_l - 16'd3000);
        write_regs(65535, 0, 0, 1'b1);
        send_angles(cur_r + 16'd1000, cur_l);
        send_angles(cur_r - 16'd1000, cur_l + 16'd500);

        write_regs(65535, 65535, 1, 1'b0);
        random_run(150);
        write_regs(65535, 65535, 1048575, 1'b1);
        random_run(150);
        write_regs(0, 65535, 1, 1'b0);
        hold_req = 1'b1;
        random_run(150);
        for (int p = 0; p < 4; p++)
        begin
            write_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(1, 1048575), p[0]);
            random_run(150);
        end
        write_regs(1, 1, 1, 1'b0);
        random_run(150);
        in_valid <= 1'b0;

        while (odo.expected_poses.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (odo.errors == 0 && odo.expected_poses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: files.f
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_dp.sv
rtl/differential_drive_odometry_unit.sv
tb/testbench.sv
